/* rtl/dhd_pkg.sv */
`timescale 1ns / 1ps
// Detection head decode package: field widths, register indexes and reset values.
// No dependencies; used by detection_head_decode_top.
package dhd_pkg;

	// Default number of class scores per anchor
	localparam int MaxClassesDef = 128;

	// Field widths
	localparam int CoordW = 16;   // signed Q11.4 box fields
	localparam int ScoreW = 16;   // Q0.16 scores
	localparam int InvW   = 24;   // Q8.16 inverse scale
	localparam int PadW   = 15;   // Q11.4 pad
	localparam int PixW   = 14;   // image pixels
	localparam int ClassW = 7;    // reported class index
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;

	// Letterbox arithmetic: Q.5 numerator times Q8.16 gives Q.21
	localparam int NumW  = 19;
	localparam int ProdW = 44;
	localparam int FracW = 21;

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_INVERSE_SCALE   = 3'd1,
		REG_PAD_LEFT        = 3'd2,
		REG_PAD_TOP         = 3'd3,
		REG_IMAGE_WIDTH     = 3'd4,
		REG_IMAGE_HEIGHT    = 3'd5
	} reg_index_t;

	// Register reset values
	localparam logic [ScoreW-1:0] ThresholdRst = 16'd16384;
	localparam logic [InvW-1:0]   InvScaleRst  = 24'd65536;
	localparam logic [PadW-1:0]   PadRst       = 15'd0;
	localparam logic [PixW-1:0]   ImageDimRst  = 14'd640;

	// Decoded position and length of one axis, whole pixels
	typedef struct packed {
		logic [PixW-1:0] pos;
		logic [PixW-1:0] len;
	} axis_t;

	// Clamp one axis to [0, limit] and trim its length to the image edge.
	function automatic axis_t clamp_axis(logic signed [ProdW-1:0] pos_in,
			logic signed [ProdW-1:0] len_in, logic [PixW-1:0] limit);
		logic signed [ProdW-1:0] bound;
		logic signed [ProdW-1:0] pos;
		logic signed [ProdW-1:0] len;
		logic signed [ProdW-1:0] room;
		axis_t res;
		bound = $signed({{(ProdW-PixW-FracW){1'b0}}, limit, {FracW{1'b0}}});
		pos = pos_in;
		if (pos > bound) begin
			pos = bound;
		end
		if (pos < 0) begin
			pos = '0;
		end
		room = bound - pos;
		len = len_in;
		if (len > room) begin
			len = room;
		end
		if (len < 0) begin
			len = '0;
		end
		res.pos = pos[FracW +: PixW];
		res.len = len[FracW +: PixW];
		return res;
	endfunction

endpackage

/* rtl/detection_head_decode_top.sv */
`timescale 1ns / 1ps
// Detection head decode top level: per-anchor best-class search and box decode.
// Depends on dhd_pkg for widths, register indexes and the axis clamp function.
//
// Usage
//  - Input channel (in_valid/in_ready): one transaction per class score of an
//    anchor, carrying that anchor's box fields; last_class marks the final one.
//    Only the box fields of the last-class transaction are used.
//  - Output channel (out_valid/out_ready): at most one box per anchor, emitted
//    when the best class score is at or above score_threshold.
//  - Configuration: cfg_en writes cfg_data to register cfg_index at the clock edge;
//    indexes beyond the list are dropped. Write only while the block is idle.
//  - Throughput: one input transaction per cycle unless a stall drops in_ready.
//  - Pipeline: the edge that accepts a box's last-class transaction loads the
//    multiply stage; the clamped box then moves into the output register,
//    which drives out_valid, once that register can advance.
//  - Stall: while out_valid is held without out_ready the two stages fill;
//    in_ready drops only when both hold a box. Non-emitting scores still wait
//    on in_ready but never occupy a stage.
//  - Reset: arst_n clears the running maximum, the class counter, stage valid
//    bits and loads the register defaults (threshold 0.25, unit scale, no pad,
//    640 x 640 image).
//  - Scores past MAX_CLASSES for one anchor are ignored, including the score
//    of the last-class transaction once the limit is reached.
module detection_head_decode_top #(
	parameter int MAX_CLASSES = dhd_pkg::MaxClassesDef
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_en,
	input  logic [dhd_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [dhd_pkg::CfgDataW-1:0]          cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [dhd_pkg::CoordW-1:0]     center_x,
	input  logic signed [dhd_pkg::CoordW-1:0]     center_y,
	input  logic signed [dhd_pkg::CoordW-1:0]     box_width,
	input  logic signed [dhd_pkg::CoordW-1:0]     box_height,
	input  logic [dhd_pkg::ScoreW-1:0]            class_score,
	input  logic                                  last_class,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [dhd_pkg::PixW-1:0]              left,
	output logic [dhd_pkg::PixW-1:0]              top,
	output logic [dhd_pkg::PixW-1:0]              width,
	output logic [dhd_pkg::PixW-1:0]              height,
	output logic [dhd_pkg::ScoreW-1:0]            score,
	output logic [dhd_pkg::ClassW-1:0]            class_index
);

	// Counter holds 0..MAX_CLASSES; best class holds 0..MAX_CLASSES-1
	localparam int CntW = $clog2(MAX_CLASSES + 1);
	localparam int ClsW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int NumW  = dhd_pkg::NumW;
	localparam int ProdW = dhd_pkg::ProdW;

	// Configuration registers
	logic [dhd_pkg::ScoreW-1:0] thr_q;
	logic [dhd_pkg::InvW-1:0]   inv_q;
	logic [dhd_pkg::PadW-1:0]   pad_left_q;
	logic [dhd_pkg::PadW-1:0]   pad_top_q;
	logic [dhd_pkg::PixW-1:0]   img_w_q;
	logic [dhd_pkg::PixW-1:0]   img_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= dhd_pkg::ThresholdRst;
			inv_q      <= dhd_pkg::InvScaleRst;
			pad_left_q <= dhd_pkg::PadRst;
			pad_top_q  <= dhd_pkg::PadRst;
			img_w_q    <= dhd_pkg::ImageDimRst;
			img_h_q    <= dhd_pkg::ImageDimRst;
		end else if (cfg_en) begin
			case (cfg_index)
				dhd_pkg::REG_SCORE_THRESHOLD: thr_q      <= cfg_data[dhd_pkg::ScoreW-1:0];
				dhd_pkg::REG_INVERSE_SCALE:   inv_q      <= cfg_data[dhd_pkg::InvW-1:0];
				dhd_pkg::REG_PAD_LEFT:        pad_left_q <= cfg_data[dhd_pkg::PadW-1:0];
				dhd_pkg::REG_PAD_TOP:         pad_top_q  <= cfg_data[dhd_pkg::PadW-1:0];
				dhd_pkg::REG_IMAGE_WIDTH:     img_w_q    <= cfg_data[dhd_pkg::PixW-1:0];
				dhd_pkg::REG_IMAGE_HEIGHT:    img_h_q    <= cfg_data[dhd_pkg::PixW-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake: each stage advances when empty or when the next one does
	logic v_s1;
	logic out_valid_q;
	logic adv_out;
	logic adv_s1;
	logic accept;

	assign adv_out  = !out_valid_q || out_ready;
	assign adv_s1   = !v_s1 || adv_out;
	assign in_ready = adv_s1;
	assign accept   = in_valid && in_ready;

	// Running maximum over the class scores of the current anchor
	logic [dhd_pkg::ScoreW-1:0] best_q;
	logic [ClsW-1:0]            bcls_q;
	logic [CntW-1:0]            cnt_q;
	logic                       take;
	logic                       upd;
	logic [dhd_pkg::ScoreW-1:0] best_now;
	logic [ClsW-1:0]            bcls_now;
	logic                       emit;

	assign take     = cnt_q < CntW'(MAX_CLASSES);
	assign upd      = take && (class_score > best_q);
	assign best_now = upd ? class_score : best_q;
	assign bcls_now = upd ? cnt_q[ClsW-1:0] : bcls_q;
	assign emit     = last_class && (best_now >= thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			bcls_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (last_class) begin
				// restart for the next anchor, whether or not a box goes out
				best_q <= '0;
				bcls_q <= '0;
				cnt_q  <= '0;
			end else begin
				best_q <= best_now;
				bcls_q <= bcls_now;
				if (take) begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
		end
	end

	// Letterbox undo: (2*center - size - 2*pad) * inv and 2 * size * inv, in Q.21
	logic signed [NumW-1:0]  num_x;
	logic signed [NumW-1:0]  num_y;
	logic signed [dhd_pkg::InvW:0] inv_s;
	logic signed [ProdW-1:0] pos_x;
	logic signed [ProdW-1:0] pos_y;
	logic signed [ProdW-1:0] len_x;
	logic signed [ProdW-1:0] len_y;

	assign inv_s = $signed({1'b0, inv_q});
	assign num_x = (NumW'(center_x) <<< 1) - NumW'(box_width)
		- $signed({{(NumW-dhd_pkg::PadW-1){1'b0}}, pad_left_q, 1'b0});
	assign num_y = (NumW'(center_y) <<< 1) - NumW'(box_height)
		- $signed({{(NumW-dhd_pkg::PadW-1){1'b0}}, pad_top_q, 1'b0});
	assign pos_x = ProdW'(num_x) * ProdW'(inv_s);
	assign pos_y = ProdW'(num_y) * ProdW'(inv_s);
	assign len_x = (ProdW'(box_width) * ProdW'(inv_s)) <<< 1;
	assign len_y = (ProdW'(box_height) * ProdW'(inv_s)) <<< 1;

	// Stage 1: products, best score and class of an emitting anchor
	logic signed [ProdW-1:0]    pos_x_s1;
	logic signed [ProdW-1:0]    pos_y_s1;
	logic signed [ProdW-1:0]    len_x_s1;
	logic signed [ProdW-1:0]    len_y_s1;
	logic [dhd_pkg::ScoreW-1:0] score_s1;
	logic [ClsW-1:0]            cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && accept && emit) begin
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			len_x_s1 <= len_x;
			len_y_s1 <= len_y;
			score_s1 <= best_now;
			cls_s1   <= bcls_now;
		end
	end

	// Stage 2: clamp to the image and truncate into the output register
	dhd_pkg::axis_t ax_x;
	dhd_pkg::axis_t ax_y;
	logic [ClsW+dhd_pkg::ClassW-1:0] cls_ext;

	assign ax_x    = dhd_pkg::clamp_axis(pos_x_s1, len_x_s1, img_w_q);
	assign ax_y    = dhd_pkg::clamp_axis(pos_y_s1, len_y_s1, img_h_q);
	assign cls_ext = {{dhd_pkg::ClassW{1'b0}}, cls_s1};

	logic [dhd_pkg::PixW-1:0]   left_q;
	logic [dhd_pkg::PixW-1:0]   top_q;
	logic [dhd_pkg::PixW-1:0]   width_q;
	logic [dhd_pkg::PixW-1:0]   height_q;
	logic [dhd_pkg::ScoreW-1:0] score_q;
	logic [dhd_pkg::ClassW-1:0] cls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			left_q   <= ax_x.pos;
			width_q  <= ax_x.len;
			top_q    <= ax_y.pos;
			height_q <= ax_y.len;
			score_q  <= score_s1;
			cls_q    <= cls_ext[dhd_pkg::ClassW-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign left        = left_q;
	assign top         = top_q;
	assign width       = width_q;
	assign height      = height_q;
	assign score       = score_q;
	assign class_index = cls_q;

endmodule

/* tb/sv/tb_detection_head_decode_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for detection_head_decode_top: directed score table, then
// random anchors under several register settings and idle/stall mixes.
// Depends on dhd_pkg and detection_head_decode_top only.
module tb_detection_head_decode_top;
	import dhd_pkg::*;

	// Run limits
	localparam int CycleLimit   = 400000;
	localparam int DrainCycles  = 8;
	localparam int MaxGap       = 40;
	localparam int PhaseItems   = 60;
	localparam int PhaseCount   = 8;
	localparam int ClassLimit   = MaxClassesDef;

	// Index with no register behind it; the block must drop writes to it
	localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

	// Register settings used per phase
	typedef enum int {
		CFG_TYPICAL,   // moderate random values
		CFG_TOP,       // every register at its upper extreme, threshold 0
		CFG_BOTTOM,    // every register at its lower extreme, threshold max
		CFG_ANY        // full-range random values
	} cfg_kind_t;

	// One input transaction: a class score plus the anchor's box fields
	typedef struct packed {
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] bw;
		logic signed [CoordW-1:0] bh;
		logic [ScoreW-1:0]        sc;
		logic                     last;
	} score_beat_t;

	// One decoded box as it leaves the block
	typedef struct packed {
		logic [PixW-1:0]   left;
		logic [PixW-1:0]   top;
		logic [PixW-1:0]   wid;
		logic [PixW-1:0]   hgt;
		logic [ScoreW-1:0] score;
		logic [ClassW-1:0] cls;
	} decoded_box_t;

	// Directed row: when typed is set, the box (or its absence) is written out by hand
	typedef struct packed {
		score_beat_t  beat;
		logic         typed;
		logic         emits;
		decoded_box_t box;
	} score_row_t;

	// All directed rows run at the reset register values:
	// threshold 16384, unit scale, no pad, 640 x 640 image.
	localparam int RowCount = 16;
	localparam score_row_t ScoreTable [RowCount] = '{
		// single-class anchor, full score: plain box inside the image
		'{'{16'sd1600, 16'sd3200, 16'sd800, 16'sd320, 16'hFFFF, 1'b1}, 1'b1, 1'b1,
			'{14'd75, 14'd190, 14'd50, 14'd20, 16'hFFFF, 7'd0}},
		// one below threshold: nothing comes out
		'{'{16'sd1600, 16'sd1600, 16'sd160, 16'sd160, 16'd16383, 1'b1}, 1'b1, 1'b0, '0},
		// exactly at threshold, zero-size box at the origin
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd16384, 1'b1}, 1'b1, 1'b1,
			'{14'd0, 14'd0, 14'd0, 14'd0, 16'd16384, 7'd0}},
		// zero score never reaches the threshold
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}, 1'b1, 1'b0, '0},
		// four-class anchor with a tie: the first of the equal scores wins
		'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd100, 1'b0}, 1'b0, 1'b0, '0},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd30000, 1'b0}, 1'b0, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd30000, 1'b0}, 1'b0, 1'b0, '0},
		'{'{16'sd5120, 16'sd5120, 16'sd10240, 16'sd10240, 16'd20000, 1'b1}, 1'b1, 1'b1,
			'{14'd0, 14'd0, 14'd640, 14'd640, 16'd30000, 7'd1}},
		// largest center/width on x, smallest on y, then the reverse: clamped to the image corners
		'{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1}, 1'b1, 1'b1,
			'{14'd640, 14'd0, 14'd0, 14'd0, 16'hFFFF, 7'd0}},
		'{'{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1}, 1'b1, 1'b1,
			'{14'd0, 14'd640, 14'd0, 14'd0, 16'hFFFF, 7'd0}},
		// all-zero anchor of two classes
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0}, 1'b0, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}, 1'b1, 1'b0, '0},
		// box fields of earlier classes are junk; only the last one counts
		'{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd5, 1'b0}, 1'b0, 1'b0, '0},
		'{'{16'sd3200, 16'sd1600, 16'sd1600, 16'sd800, 16'd40000, 1'b1}, 1'b1, 1'b1,
			'{14'd150, 14'd75, 14'd100, 14'd50, 16'd40000, 7'd1}},
		// width trimmed at the right edge, top clipped to zero
		'{'{16'sd10000, 16'sd160, 16'sd1600, 16'sd640, 16'd50000, 1'b1}, 1'b1, 1'b1,
			'{14'd575, 14'd0, 14'd65, 14'd40, 16'd50000, 7'd0}},
		// fractional pixels truncate
		'{'{16'sd17, 16'sd25, 16'sd3, -16'sd1, 16'd30000, 1'b1}, 1'b0, 1'b0, '0}
	};

	// Phase schedule: no idling, sender idle, receiver stall, both; then again
	localparam int PhaseIdle  [PhaseCount] = '{0, 58, 0, 19, 0, 58, 0, 19};
	localparam int PhaseStall [PhaseCount] = '{0, 0, 58, 19, 0, 0, 58, 19};
	localparam cfg_kind_t PhaseCfg [PhaseCount] = '{CFG_TYPICAL, CFG_TOP, CFG_ANY,
		CFG_BOTTOM, CFG_TYPICAL, CFG_ANY, CFG_TYPICAL, CFG_TOP};

	// DUT ports; the inputs driven here are all known from time zero
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_en = 1'b0;
	logic [CfgIdxW-1:0]       cfg_index = '0;
	logic [CfgDataW-1:0]      cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [CoordW-1:0] center_x = '0;
	logic signed [CoordW-1:0] center_y = '0;
	logic signed [CoordW-1:0] box_width = '0;
	logic signed [CoordW-1:0] box_height = '0;
	logic [ScoreW-1:0]        class_score = '0;
	logic                     last_class = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [PixW-1:0]          left;
	logic [PixW-1:0]          top;
	logic [PixW-1:0]          width;
	logic [PixW-1:0]          height;
	logic [ScoreW-1:0]        score;
	logic [ClassW-1:0]        class_index;

	// Shadow copy of the registers
	logic [ScoreW-1:0] thr_cfg      = ThresholdRst;
	logic [InvW-1:0]   inv_cfg      = InvScaleRst;
	logic [PadW-1:0]   pad_left_cfg = PadRst;
	logic [PadW-1:0]   pad_top_cfg  = PadRst;
	logic [PixW-1:0]   img_w_cfg    = ImageDimRst;
	logic [PixW-1:0]   img_h_cfg    = ImageDimRst;

	// Running maximum of the anchor in flight
	logic [ScoreW-1:0] best_score_q = '0;
	logic [ClassW-1:0] best_class_q = '0;
	int                classes_seen = 0;

	decoded_box_t pending_boxes[$];
	int           mismatches = 0;
	int           cycle_count = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;

	detection_head_decode_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_en      (cfg_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.center_x    (center_x),
		.center_y    (center_y),
		.box_width   (box_width),
		.box_height  (box_height),
		.class_score (class_score),
		.last_class  (last_class),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left        (left),
		.top         (top),
		.width       (width),
		.height      (height),
		.score       (score),
		.class_index (class_index)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses a box
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: drop ready at random per cycle, at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Undo the letterbox on one axis in Q.21 and clamp it to [0, limit_px].
	// The trimmed length uses the clamped but untruncated position.
	function automatic void letterbox_axis(input longint center, input longint span,
			input longint pad, input longint limit_px,
			output logic [PixW-1:0] pos_px, output logic [PixW-1:0] len_px);
		longint     inv;
		longint     bound;
		longint     pos;
		longint     len;
		longint     room;
		logic [63:0] bits;
		inv = longint'(inv_cfg);
		bound = limit_px <<< FracW;
		pos = (2 * center - span - 2 * pad) * inv;
		len = span * inv * 2;
		if (pos > bound) begin
			pos = bound;
		end
		if (pos < 0) begin
			pos = 0;
		end
		room = bound - pos;
		if (len > room) begin
			len = room;
		end
		if (len < 0) begin
			len = 0;
		end
		bits = pos >>> FracW;
		pos_px = bits[PixW-1:0];
		bits = len >>> FracW;
		len_px = bits[PixW-1:0];
	endfunction

	// Fold one score into the running maximum; on the last class decide whether a
	// box comes out, then restart for the next anchor.
	function automatic logic take_score(input score_beat_t beat, output decoded_box_t box);
		logic emitted;
		emitted = 1'b0;
		box = '0;
		// past the class limit, scores are dropped (the last one's too)
		if (classes_seen < ClassLimit) begin
			if (beat.sc > best_score_q) begin
				best_score_q = beat.sc;
				best_class_q = classes_seen[ClassW-1:0];
			end
			classes_seen++;
		end
		if (beat.last) begin
			if (best_score_q >= thr_cfg) begin
				letterbox_axis(longint'(beat.cx), longint'(beat.bw), longint'(pad_left_cfg),
					longint'(img_w_cfg), box.left, box.wid);
				letterbox_axis(longint'(beat.cy), longint'(beat.bh), longint'(pad_top_cfg),
					longint'(img_h_cfg), box.top, box.hgt);
				box.score = best_score_q;
				box.cls = best_class_q;
				emitted = 1'b1;
			end
			best_score_q = '0;
			best_class_q = '0;
			classes_seen = 0;
		end
		return emitted;
	endfunction

	// Present one score transaction after a random idle gap and hold it until
	// accepted. Valid stays high afterwards so the next transaction can follow
	// back to back; the caller drops it when the stream pauses.
	task automatic send_score(input score_beat_t beat, input logic typed,
			input logic typed_emits, input decoded_box_t typed_box);
		int           gap;
		logic         emitted;
		decoded_box_t box;
		gap = 0;
		while (gap < MaxGap && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		center_x    <= beat.cx;
		center_y    <= beat.cy;
		box_width   <= beat.bw;
		box_height  <= beat.bh;
		class_score <= beat.sc;
		last_class  <= beat.last;
		do @(posedge clk); while (!in_ready);
		emitted = take_score(beat, box);
		// hand-written rows override the prediction
		if (typed) begin
			emitted = typed_emits;
			box = typed_box;
		end
		if (emitted) begin
			pending_boxes = {pending_boxes, box};
		end
	endtask

	// Stream one anchor of n_classes scores. With peak_last the final score is
	// the unique maximum, which shows whether the last class was counted.
	task automatic send_anchor(input int n_classes, input logic peak_last);
		score_beat_t beat;
		logic [ScoreW-1:0] prev;
		prev = '0;
		for (int k = 0; k < n_classes; k++) begin
			if ($urandom_range(3) == 0) begin
				beat.cx = CoordW'($urandom_range(65535));
				beat.cy = CoordW'($urandom_range(65535));
				beat.bw = CoordW'($urandom_range(65535));
				beat.bh = CoordW'($urandom_range(65535));
			end else begin
				beat.cx = CoordW'($urandom_range(16383));
				beat.cy = CoordW'($urandom_range(16383));
				beat.bw = CoordW'($urandom_range(8191));
				beat.bh = CoordW'($urandom_range(8191));
			end
			case ($urandom_range(9))
				0: beat.sc = '1;
				1: beat.sc = '0;
				2: beat.sc = thr_cfg;
				3: beat.sc = prev;
				default: beat.sc = ScoreW'($urandom_range(65535));
			endcase
			beat.last = (k == n_classes - 1);
			if (peak_last) begin
				if (beat.last) begin
					beat.sc = '1;
				end else if (beat.sc == '1) begin
					beat.sc = beat.sc - 1'b1;
				end
			end
			prev = beat.sc;
			send_score(beat, 1'b0, 1'b0, '0);
		end
	endtask

	// Write one register at the next edge; keep the enable up for the caller
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SCORE_THRESHOLD: thr_cfg = val[ScoreW-1:0];
			REG_INVERSE_SCALE:   inv_cfg = val[InvW-1:0];
			REG_PAD_LEFT:        pad_left_cfg = val[PadW-1:0];
			REG_PAD_TOP:         pad_top_cfg = val[PadW-1:0];
			REG_IMAGE_WIDTH:     img_w_cfg = val[PixW-1:0];
			REG_IMAGE_HEIGHT:    img_h_cfg = val[PixW-1:0];
			default: ;
		endcase
	endtask

	// Load a full register set, then poke the spare index which must be dropped
	task automatic program_regs(input cfg_kind_t kind);
		logic [CfgDataW-1:0] thr;
		logic [CfgDataW-1:0] inv;
		logic [CfgDataW-1:0] pad_l;
		logic [CfgDataW-1:0] pad_t;
		logic [CfgDataW-1:0] img_w;
		logic [CfgDataW-1:0] img_h;
		case (kind)
			CFG_TOP: begin
				thr = '0;
				inv = 24'hFFFFFF;
				pad_l = 24'h7FFF;
				pad_t = 24'h7FFF;
				img_w = 24'd16383;
				img_h = 24'd16383;
			end
			CFG_BOTTOM: begin
				// zero image: every position and size clamps to 0
				thr = 24'hFFFF;
				inv = '0;
				pad_l = '0;
				pad_t = '0;
				img_w = '0;
				img_h = '0;
			end
			CFG_ANY: begin
				thr = CfgDataW'($urandom_range(65535));
				inv = CfgDataW'($urandom_range(24'hFFFFFF));
				pad_l = CfgDataW'($urandom_range(32767));
				pad_t = CfgDataW'($urandom_range(32767));
				img_w = CfgDataW'($urandom_range(16383));
				img_h = CfgDataW'($urandom_range(16383));
			end
			default: begin
				thr = CfgDataW'($urandom_range(40000));
				inv = CfgDataW'($urandom_range(196608, 16384));
				pad_l = CfgDataW'($urandom_range(2048));
				pad_t = CfgDataW'($urandom_range(2048));
				img_w = ($urandom_range(3) == 0) ? 24'd8192
					: CfgDataW'($urandom_range(8192, 1));
				img_h = ($urandom_range(3) == 0) ? 24'd8192
					: CfgDataW'($urandom_range(8192, 1));
			end
		endcase
		write_reg(REG_SCORE_THRESHOLD, thr);
		write_reg(REG_INVERSE_SCALE, inv);
		write_reg(REG_PAD_LEFT, pad_l);
		write_reg(REG_PAD_TOP, pad_t);
		write_reg(REG_IMAGE_WIDTH, img_w);
		write_reg(REG_IMAGE_HEIGHT, img_h);
		write_reg(RegSpare, CfgDataW'($urandom_range(24'hFFFFFF)));
		cfg_en <= 1'b0;
	endtask

	// Hold until every expected box is out, then let the pipeline settle
	task automatic wait_drained();
		while (pending_boxes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Output monitor: compare each accepted box with the oldest expectation
	always @(posedge clk) begin
		decoded_box_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_boxes.size() == 0) begin
				$error("box with no expectation: left %0d top %0d score %0d class %0d",
					left, top, score, class_index);
				mismatches++;
			end else begin
				want = pending_boxes.pop_front();
				check_field("left", int'(want.left), int'(left));
				check_field("top", int'(want.top), int'(top));
				check_field("width", int'(want.wid), int'(width));
				check_field("height", int'(want.hgt), int'(height));
				check_field("score", int'(want.score), int'(score));
				check_field("class_index", int'(want.cls), int'(class_index));
			end
		end
	end

	// Main sequence: reset, directed table, then the random phases
	initial begin
		int sent;
		int n_classes;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < RowCount; r++) begin
			send_score(ScoreTable[r].beat, ScoreTable[r].typed, ScoreTable[r].emits,
				ScoreTable[r].box);
		end
		in_valid <= 1'b0;

		for (int p = 0; p < PhaseCount; p++) begin
			// registers change only with the block empty
			wait_drained();
			program_regs(PhaseCfg[p]);
			idle_pct = PhaseIdle[p];
			stall_pct = PhaseStall[p];
			sent = 0;
			if (p == 0) begin
				// exactly the class limit: the last class is counted (index 127);
				// just over it: the last score is dropped
				send_anchor(ClassLimit, 1'b1);
				send_anchor(ClassLimit + 3, 1'b1);
			end
			while (sent < PhaseItems) begin
				pick = $urandom_range(99);
				if (pick < 3) begin
					n_classes = $urandom_range(ClassLimit + 6, ClassLimit + 1);
				end else if (pick < 5) begin
					n_classes = ClassLimit;
				end else if (pick < 15) begin
					n_classes = $urandom_range(40, 9);
				end else begin
					n_classes = $urandom_range(8, 1);
				end
				send_anchor(n_classes, $urandom_range(7) == 0);
				sent += n_classes;
			end
			in_valid <= 1'b0;
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/dhd_pkg.sv
rtl/detection_head_decode_top.sv
tb/sv/tb_detection_head_decode_top.sv
